// ===== rtl/dsst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_pkg: shared types and constants of the diffusion stencil step
// Field widths, fixed-point constants, the configuration register map and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsst_pkg;

	// Field and register widths.
	localparam int CONC_W      = 32;
	localparam int COUNT_W     = 31;
	localparam int FO_W        = 15;
	localparam int SCALE_W     = 32;
	localparam int OUTER_CFG_W = 11;
	localparam int INNER_CFG_W = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// Fixed-point arithmetic.
	localparam int FRAC_W   = 16;
	localparam int FO_MAX   = 16384;
	localparam int ONE_Q16  = 65536;
	localparam int HALF_Q16 = 32768;
	localparam int WGT_W    = 17;
	localparam int SUM_W    = 34;
	localparam int MUL_A_W  = 34;
	localparam int MUL_B_W  = 32;
	localparam int PROD_W   = 64;
	localparam int ACC_W    = 49;

	// Reset value of the count scale (1.0 in Q16.16).
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

	// Three rotating row slots in the line buffer.
	localparam int ROW_SLOTS = 3;
	typedef logic [1:0] slot_t;

	// Configuration register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOURIER = 2'd0,
		CFG_SCALE   = 2'd1,
		CFG_OUTER   = 2'd2,
		CFG_INNER   = 2'd3
	} cfg_idx_t;

	// Which neighbor the line buffer read fetches.
	typedef enum logic [1:0] {
		RD_CTR   = 2'd0,
		RD_UP    = 2'd1,
		RD_LEFT  = 2'd2,
		RD_RIGHT = 2'd3
	} rd_sel_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_FS  = 2'd0,
		MUL_WC  = 2'd1,
		MUL_CNT = 2'd2
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    accept;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_ctr;
		logic    cap_up;
		logic    cap_left;
		logic    sum_en;
		logic    mul_en;
		mul_op_t mul_op;
		logic    acc_en;
		logic    conc_en;
		logic    out_load;
		logic    flush_start;
		logic    flush_next;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trivial;
		logic has_emit;
		logic grid_last;
		logic flush_active;
		logic fcol_end;
		logic out_free;
	} sts_t;

	// Slot that held the row before the given one.
	function automatic slot_t slot_prev(input slot_t s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

	// Slot that takes the row after the given one.
	function automatic slot_t slot_next(input slot_t s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

endpackage

// ===== rtl/dsst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module dsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dsst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_ctrl: sequencer of the diffusion stencil step
// Accepts one cell, walks the neighbor reads, the shared multiplier steps
// and the result hand-off, and runs the last-row flush after the final cell.
// ----------------------------------------------------------------------------
module dsst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dsst_pkg::sts_t sts,
	output dsst_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_RD_C = 11'b000_0000_0010,
		ST_RD_U = 11'b000_0000_0100,
		ST_RD_L = 11'b000_0000_1000,
		ST_RD_R = 11'b000_0001_0000,
		ST_SUM  = 11'b000_0010_0000,
		ST_MUL1 = 11'b000_0100_0000,
		ST_MUL2 = 11'b000_1000_0000,
		ST_ADD  = 11'b001_0000_0000,
		ST_CNT  = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_flush_q;
	logic   pend_flush_d;

	// Input is taken only between results.
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = dsst_pkg::RD_CTR;
		cmd.mul_op   = dsst_pkg::MUL_FS;
		state_d      = state_q;
		pend_flush_d = pend_flush_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept   = 1'b1;
					pend_flush_d = !sts.trivial && sts.grid_last;
					if (sts.trivial) begin
						state_d = ST_CNT;
					end else if (sts.has_emit) begin
						state_d = ST_RD_C;
					end
				end
			end
			ST_RD_C: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dsst_pkg::RD_CTR;
				state_d    = ST_RD_U;
			end
			ST_RD_U: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = dsst_pkg::RD_UP;
				cmd.cap_ctr = 1'b1;
				state_d     = ST_RD_L;
			end
			ST_RD_L: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dsst_pkg::RD_LEFT;
				cmd.cap_up = 1'b1;
				state_d    = ST_RD_R;
			end
			ST_RD_R: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = dsst_pkg::RD_RIGHT;
				cmd.cap_left = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dsst_pkg::MUL_FS;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dsst_pkg::MUL_WC;
				cmd.acc_en = 1'b1;
				state_d    = ST_ADD;
			end
			ST_ADD: begin
				cmd.conc_en = 1'b1;
				state_d     = ST_CNT;
			end
			ST_CNT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dsst_pkg::MUL_CNT;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// Hand the result to the output register, then pick the next job.
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.flush_active) begin
						if (sts.fcol_end) begin
							state_d = ST_IDLE;
						end else begin
							cmd.flush_next = 1'b1;
							state_d        = ST_RD_C;
						end
					end else if (pend_flush_q) begin
						cmd.flush_start = 1'b1;
						pend_flush_d    = 1'b0;
						state_d         = ST_RD_C;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_flush_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_flush_q <= pend_flush_d;
		end
	end

`ifndef SYNTHESIS
	// A pass-through cell goes straight to the count multiply.
	a_trivial_to_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && sts.trivial) |=> (state_q == ST_CNT))
		else $error("pass-through cell did not go to count step");

	// A finished result holds while the output register is full.
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> (state_q == ST_DONE))
		else $error("result left before output register was free");

	// With no flush work left, a delivered result returns to idle.
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && sts.out_free && !sts.flush_active && !pend_flush_q)
		|=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle");
`endif

endmodule

// ===== rtl/dsst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_dp: datapath of the diffusion stencil step
// Configuration registers, grid indices, the three-row line buffer, the
// neighbor sum, one shared multiplier, rounding and the output register.
// ----------------------------------------------------------------------------
module dsst_dp #(
	parameter int MAX_OUTER = 1024,
	parameter int MAX_INNER = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dsst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsst_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [dsst_pkg::CONC_W-1:0]        conc_in,
	input  dsst_pkg::cmd_t                     cmd,
	output dsst_pkg::sts_t                     sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [dsst_pkg::CONC_W-1:0]        conc_out,
	output logic [dsst_pkg::COUNT_W-1:0]       count_out,
	output logic                               last_cell
);

	localparam int OW      = $clog2(MAX_OUTER);
	localparam int IW      = $clog2(MAX_INNER);
	localparam int EOW     = $clog2(MAX_OUTER + 1);
	localparam int EIW     = $clog2(MAX_INNER + 1);
	localparam int OCW     = (dsst_pkg::OUTER_CFG_W > EOW) ? dsst_pkg::OUTER_CFG_W : EOW;
	localparam int ICW     = (dsst_pkg::INNER_CFG_W > EIW) ? dsst_pkg::INNER_CFG_W : EIW;
	localparam int DEPTH   = dsst_pkg::ROW_SLOTS * MAX_INNER;
	localparam int AW      = $clog2(DEPTH);
	localparam int ConcW   = dsst_pkg::CONC_W;
	localparam int SumW    = dsst_pkg::SUM_W;
	localparam int FoW     = dsst_pkg::FO_W;
	localparam int WgtW    = dsst_pkg::WGT_W;
	localparam int MulAW   = dsst_pkg::MUL_A_W;
	localparam int MulBW   = dsst_pkg::MUL_B_W;
	localparam int ProdW   = dsst_pkg::PROD_W;
	localparam int AccW    = dsst_pkg::ACC_W;
	localparam int AccSumW = dsst_pkg::ACC_W + 1;
	localparam int FracW   = dsst_pkg::FRAC_W;
	localparam int CntW    = dsst_pkg::PROD_W - dsst_pkg::FRAC_W + 1;
	localparam int CountW  = dsst_pkg::COUNT_W;

	// Configuration registers.
	logic [dsst_pkg::FO_W-1:0]        fo_q;
	logic [dsst_pkg::SCALE_W-1:0]     scale_q;
	logic [dsst_pkg::OUTER_CFG_W-1:0] cfg_outer_q;
	logic [dsst_pkg::INNER_CFG_W-1:0] cfg_inner_q;
	logic                             size_wr;

	// Effective grid size.
	logic [OCW-1:0] outer_x;
	logic [OCW-1:0] outer_eff_x;
	logic [ICW-1:0] inner_x;
	logic [ICW-1:0] inner_eff_x;
	logic [EOW-1:0] n_eff;
	logic [EIW-1:0] m_eff;

	// Grid position of the next input.
	logic [OW-1:0]       outer_q;
	logic [IW-1:0]       inner_q;
	dsst_pkg::slot_t     slot_q;
	logic                inner_end;
	logic                outer_end;
	logic                trivial;
	logic                grid_last;

	// Item context and flush walk.
	dsst_pkg::slot_t     in_slot_q;
	logic [IW-1:0]       in_col_q;
	logic                row1_q;
	logic                res_last_q;
	logic                flush_q;
	logic [IW-1:0]       fcol_q;
	logic                fcol_end;

	// Stencil target and neighbor addresses.
	dsst_pkg::slot_t     tslot_c;
	dsst_pkg::slot_t     tslot_u;
	logic [IW-1:0]       tcol;
	logic [EIW-1:0]      tcol_inc;
	logic [IW-1:0]       lcol;
	logic [IW-1:0]       rcol;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic                ram_we;
	logic [ConcW-1:0]    rdata;

	// Arithmetic.
	logic [ConcW-1:0]    below_q;
	logic [ConcW-1:0]    ctr_q;
	logic [ConcW-1:0]    up_q;
	logic [ConcW-1:0]    left_q;
	logic [ConcW-1:0]    up_v;
	logic [ConcW-1:0]    below_v;
	logic [SumW-1:0]     sum_q;
	logic [FoW-1:0]      fo_eff;
	logic [WgtW-1:0]     wgt;
	logic [MulAW-1:0]    mul_a;
	logic [MulBW-1:0]    mul_b;
	logic [MulAW+MulBW-1:0] mul_full;
	logic [ProdW-1:0]    prod_q;
	logic [AccW-1:0]     acc_q;
	logic [AccSumW-1:0]  conc_sum;
	logic [ConcW-1:0]    conc_q;
	logic [CntW-1:0]     cnt_raw;
	logic [CountW-1:0]   count_next;

	// Output register.
	logic                out_valid_q;
	logic [ConcW-1:0]    conc_out_q;
	logic [CountW-1:0]   count_out_q;
	logic                last_q;

	function automatic logic [AW-1:0] cell_addr(input dsst_pkg::slot_t s,
		input logic [IW-1:0] c);
		return AW'(s) * AW'(MAX_INNER) + AW'(c);
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fo_q        <= '0;
			scale_q     <= dsst_pkg::SCALE_RESET;
			cfg_outer_q <= dsst_pkg::OUTER_CFG_W'(1);
			cfg_inner_q <= dsst_pkg::INNER_CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				dsst_pkg::CFG_FOURIER: fo_q        <= cfg_data[dsst_pkg::FO_W-1:0];
				dsst_pkg::CFG_SCALE:   scale_q     <= cfg_data[dsst_pkg::SCALE_W-1:0];
				dsst_pkg::CFG_OUTER:   cfg_outer_q <= cfg_data[dsst_pkg::OUTER_CFG_W-1:0];
				dsst_pkg::CFG_INNER:   cfg_inner_q <= cfg_data[dsst_pkg::INNER_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign size_wr = cfg_we && (cfg_index == dsst_pkg::CFG_OUTER ||
		cfg_index == dsst_pkg::CFG_INNER);

	// Zero counts as one; sizes above the buffer limits are clamped.
	assign outer_x = OCW'(cfg_outer_q);
	assign inner_x = ICW'(cfg_inner_q);
	always_comb begin
		if (cfg_outer_q == '0) begin
			outer_eff_x = OCW'(1);
		end else if (outer_x > MAX_OUTER) begin
			outer_eff_x = OCW'(MAX_OUTER);
		end else begin
			outer_eff_x = outer_x;
		end
		if (cfg_inner_q == '0) begin
			inner_eff_x = ICW'(1);
		end else if (inner_x > MAX_INNER) begin
			inner_eff_x = ICW'(MAX_INNER);
		end else begin
			inner_eff_x = inner_x;
		end
	end
	assign n_eff = outer_eff_x[EOW-1:0];
	assign m_eff = inner_eff_x[EIW-1:0];

	// Position flags of the next input.
	assign inner_end = (EIW'(inner_q) + EIW'(1)) == m_eff;
	assign outer_end = (EOW'(outer_q) + EOW'(1)) == n_eff;
	assign grid_last = inner_end && outer_end;
	assign trivial   = (n_eff == EOW'(1)) || (m_eff == EIW'(1));

	// Raster position and row slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= '0;
			inner_q <= '0;
			slot_q  <= '0;
		end else if (size_wr) begin
			outer_q <= '0;
			inner_q <= '0;
			slot_q  <= '0;
		end else if (cmd.accept) begin
			if (inner_end) begin
				inner_q <= '0;
				if (outer_end) begin
					outer_q <= '0;
					slot_q  <= '0;
				end else begin
					outer_q <= outer_q + OW'(1);
					slot_q  <= dsst_pkg::slot_next(slot_q);
				end
			end else begin
				inner_q <= inner_q + IW'(1);
			end
		end
	end

	// Flush mode and its column walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
			fcol_q  <= '0;
		end else if (cmd.accept) begin
			flush_q <= 1'b0;
		end else if (cmd.flush_start) begin
			flush_q <= 1'b1;
			fcol_q  <= '0;
		end else if (cmd.flush_next) begin
			fcol_q  <= fcol_q + IW'(1);
		end
	end
	assign fcol_end = (EIW'(fcol_q) + EIW'(1)) == m_eff;

	// Context of the accepted cell.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_slot_q  <= slot_q;
			in_col_q   <= inner_q;
			row1_q     <= (outer_q == OW'(1));
			res_last_q <= trivial && grid_last;
			below_q    <= conc_in;
		end
	end

	// Normal results finish the row above the input; the flush finishes the input row.
	assign tslot_c  = flush_q ? in_slot_q : dsst_pkg::slot_prev(in_slot_q);
	assign tslot_u  = flush_q ? dsst_pkg::slot_prev(in_slot_q) :
		dsst_pkg::slot_prev(dsst_pkg::slot_prev(in_slot_q));
	assign tcol     = flush_q ? fcol_q : in_col_q;
	assign tcol_inc = EIW'(tcol) + EIW'(1);

	// Edge columns mirror the opposite neighbor.
	assign lcol = (tcol == '0) ? tcol_inc[IW-1:0] : tcol - IW'(1);
	assign rcol = (tcol_inc >= m_eff) ? tcol - IW'(1) : tcol_inc[IW-1:0];

	always_comb begin
		case (cmd.rd_sel)
			dsst_pkg::RD_CTR:   raddr = cell_addr(tslot_c, tcol);
			dsst_pkg::RD_UP:    raddr = cell_addr(tslot_u, tcol);
			dsst_pkg::RD_LEFT:  raddr = cell_addr(tslot_c, lcol);
			dsst_pkg::RD_RIGHT: raddr = cell_addr(tslot_c, rcol);
			default:            raddr = cell_addr(tslot_c, tcol);
		endcase
	end

	assign waddr  = cell_addr(slot_q, inner_q);
	assign ram_we = cmd.accept && !trivial;

	// Line buffer: three row slots of one grid row each.
	dsst_ram #(
		.WIDTH (ConcW),
		.DEPTH (DEPTH)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (conc_in),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Capture the neighbors as they come out of the buffer.
	always_ff @(posedge clk) begin
		if (cmd.cap_ctr) begin
			ctr_q <= rdata;
		end
		if (cmd.cap_up) begin
			up_q <= rdata;
		end
		if (cmd.cap_left) begin
			left_q <= rdata;
		end
	end

	// Top row mirrors the cell below; bottom row mirrors the cell above.
	assign up_v    = (!flush_q && row1_q) ? below_q : up_q;
	assign below_v = flush_q ? up_q : below_q;

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sum_q <= SumW'(up_v) + SumW'(below_v) + SumW'(left_q) + SumW'(rdata);
		end
	end

	// Fourier number and center weight.
	assign fo_eff = (fo_q > FoW'(dsst_pkg::FO_MAX)) ? FoW'(dsst_pkg::FO_MAX) : fo_q;
	assign wgt    = WgtW'(dsst_pkg::ONE_Q16) - (WgtW'(fo_eff) << 2);

	// Shared multiplier.
	always_comb begin
		case (cmd.mul_op)
			dsst_pkg::MUL_FS: begin
				mul_a = sum_q;
				mul_b = MulBW'(fo_eff);
			end
			dsst_pkg::MUL_WC: begin
				mul_a = MulAW'(ctr_q);
				mul_b = MulBW'(wgt);
			end
			dsst_pkg::MUL_CNT: begin
				mul_a = MulAW'(conc_q);
				mul_b = scale_q;
			end
			default: begin
				mul_a = sum_q;
				mul_b = MulBW'(fo_eff);
			end
		endcase
	end
	assign mul_full = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_full[ProdW-1:0];
		end
		if (cmd.acc_en) begin
			acc_q <= prod_q[AccW-1:0];
		end
	end

	// New concentration, rounded half up; pass-through cells load directly.
	assign conc_sum = AccSumW'(acc_q) + AccSumW'(prod_q[AccW-1:0]) +
		AccSumW'(dsst_pkg::HALF_Q16);

	always_ff @(posedge clk) begin
		if (cmd.accept && trivial) begin
			conc_q <= conc_in;
		end else if (cmd.conc_en) begin
			conc_q <= conc_sum[FracW +: ConcW];
		end
	end

	// Molecule count, rounded half up and saturated.
	assign cnt_raw    = CntW'(prod_q[ProdW-1:FracW]) + CntW'(prod_q[FracW-1]);
	assign count_next = (|cnt_raw[CntW-1:CountW]) ? '1 : cnt_raw[CountW-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			conc_out_q  <= conc_q;
			count_out_q <= count_next;
			last_q      <= flush_q ? fcol_end : res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign conc_out  = conc_out_q;
	assign count_out = count_out_q;
	assign last_cell = last_q;

	// Status to the controller.
	always_comb begin
		sts.trivial      = trivial;
		sts.has_emit     = (outer_q != '0);
		sts.grid_last    = grid_last;
		sts.flush_active = flush_q;
		sts.fcol_end     = fcol_end;
		sts.out_free     = !out_valid_q || !out_stall;
	end

`ifndef SYNTHESIS
	// The column index never reaches the row length.
	a_inner_range: assert property (@(posedge clk) disable iff (!arst_n)
		EIW'(inner_q) < m_eff)
		else $error("inner index out of range");

	// The row index never reaches the grid height.
	a_outer_range: assert property (@(posedge clk) disable iff (!arst_n)
		EOW'(outer_q) < n_eff)
		else $error("outer index out of range");

	// The row slot rotates through three values only.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != 2'd3)
		else $error("row slot out of range");
`endif

endmodule

// ===== rtl/diffusion_stencil_step.sv =====
`timescale 1ns / 1ps
// A cell that completes an earlier row's result delivers it after the neighbor reads, sum, multiplies
// and count step; in a one-row or one-column grid each beat is passed through via the count step.
// The next beat is stalled until the result is handed off, set by the single buffer read
// port and the one shared multiplier; first-row beats are taken every cycle.
// After the final cell the block flushes the last row, one column after another.
// Reset clears control and configuration registers; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// diffusion_stencil_step: five-point explicit diffusion step on a streamed grid
// Rows arrive in raster order; each result is a cell's new concentration and
// its rounded molecule count, one row behind the input.
// ----------------------------------------------------------------------------
module diffusion_stencil_step #(
	parameter int MAX_OUTER = 1024,
	parameter int MAX_INNER = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dsst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsst_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dsst_pkg::CONC_W-1:0]     conc_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dsst_pkg::CONC_W-1:0]     conc_out,
	output logic [dsst_pkg::COUNT_W-1:0]    count_out,
	output logic                            last_cell
);

	dsst_pkg::cmd_t cmd;
	dsst_pkg::sts_t sts;
	logic           cfg_we;

	// Register writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Sequencer.
	dsst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	dsst_dp #(
		.MAX_OUTER (MAX_OUTER),
		.MAX_INNER (MAX_INNER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.conc_in   (conc_in),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.conc_out  (conc_out),
		.count_out (count_out),
		.last_cell (last_cell)
	);

endmodule

// ===== sim/diffusion_stencil_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffusion_stencil_step_checker: result predictor and scoreboard
// Watches the configuration, input and result channels of the diffusion
// stencil step. For every accepted input beat it computes the results the
// block must return, queues them, and compares each accepted result beat
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module diffusion_stencil_step_checker
	import dsst_pkg::*;
#(
	parameter int MAX_OUTER = 1024,
	parameter int MAX_INNER = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [CONC_W-1:0]     conc_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [CONC_W-1:0]     conc_out,
	input  logic [COUNT_W-1:0]    count_out,
	input  logic                  last_cell,
	output int                    pending,
	output int                    failures
);

	localparam logic [63:0] COUNT_SAT = 64'h7FFF_FFFF;

	typedef struct packed {
		logic [CONC_W-1:0]  conc;
		logic [COUNT_W-1:0] count;
		logic               last;
	} cell_result_t;

	// Own copy of the line buffer, the grid position and the registers.
	logic [CONC_W-1:0]      row_mem [ROW_SLOTS][MAX_INNER];
	logic [FO_W-1:0]        fo_reg;
	logic [SCALE_W-1:0]     scale_reg;
	logic [OUTER_CFG_W-1:0] outer_reg;
	logic [INNER_CFG_W-1:0] inner_reg;
	int unsigned            row_at;
	int unsigned            col_at;
	cell_result_t           due_cells[$];

	// Grid sizes after clamping of the raw register values.
	function automatic int unsigned grid_rows();
		if (outer_reg == 0) return 1;
		if (outer_reg > MAX_OUTER) return MAX_OUTER;
		return outer_reg;
	endfunction

	function automatic int unsigned grid_cols();
		if (inner_reg == 0) return 1;
		if (inner_reg > MAX_INNER) return MAX_INNER;
		return inner_reg;
	endfunction

	function automatic logic [CONC_W-1:0] stored(input int unsigned row, input int unsigned col);
		return row_mem[row % ROW_SLOTS][col % MAX_INNER];
	endfunction

	// Concentration times the Q16.16 scale, rounded half up and saturated.
	function automatic logic [COUNT_W-1:0] molecule_count(input logic [CONC_W-1:0] conc);
		logic [63:0] prod;
		logic [63:0] cnt;
		prod = 64'(conc) * 64'(scale_reg);
		cnt = (prod >> FRAC_W) + 64'(prod[FRAC_W-1]);
		if (cnt > COUNT_SAT) cnt = COUNT_SAT;
		return cnt[COUNT_W-1:0];
	endfunction

	// New value of one cell. A missing neighbor at an edge takes the value
	// of the opposite one.
	function automatic logic [CONC_W-1:0] diffuse_cell(input int unsigned row,
			input int unsigned col, input logic [CONC_W-1:0] below, input int unsigned m);
		logic [16:0]       fo;
		logic [CONC_W-1:0] ctr;
		logic [CONC_W-1:0] up;
		logic [CONC_W-1:0] left;
		logic [CONC_W-1:0] right;
		logic [63:0]       nsum;
		logic [63:0]       acc;
		fo = (fo_reg > FO_MAX) ? 17'(FO_MAX) : 17'(fo_reg);
		ctr = stored(row, col);
		up = (row == 0) ? below : stored(row - 1, col);
		left = (col == 0) ? stored(row, col + 1) : stored(row, col - 1);
		right = (col + 1 >= m) ? stored(row, col - 1) : stored(row, col + 1);
		nsum = 64'(up) + 64'(below) + 64'(left) + 64'(right);
		acc = 64'(fo) * nsum + 64'(ONE_Q16 - 4 * int'(fo)) * 64'(ctr) + 64'(HALF_Q16);
		return acc[FRAC_W +: CONC_W];
	endfunction

	function automatic void queue_result(input logic [CONC_W-1:0] conc, input logic last);
		due_cells.push_back('{conc: conc, count: molecule_count(conc), last: last});
	endfunction

	// One input cell: pass it through in a one-row or one-column grid; else
	// store it, finish the cell above, and flush the last row when the grid is complete.
	function automatic void absorb_cell(input logic [CONC_W-1:0] x);
		int unsigned n;
		int unsigned m;
		int unsigned i;
		int unsigned j;
		logic        fin;
		n = grid_rows();
		m = grid_cols();
		i = row_at;
		j = col_at;
		fin = (i + 1 == n) && (j + 1 == m);
		if (n == 1 || m == 1) begin
			queue_result(x, fin);
		end else begin
			row_mem[i % ROW_SLOTS][j % MAX_INNER] = x;
			if (i >= 1) queue_result(diffuse_cell(i - 1, j, x, m), 1'b0);
			if (fin) begin
				for (int unsigned c = 0; c < m; c++)
					queue_result(diffuse_cell(i, c, stored(i - 1, c), m), c + 1 == m);
			end
		end
		j++;
		if (j >= m) begin
			j = 0;
			i++;
			if (i >= n) i = 0;
		end
		row_at = i;
		col_at = j;
	endfunction

	// Channel monitor: results are checked first, then register writes and
	// input beats update the prediction.
	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			fo_reg = '0;
			scale_reg = SCALE_RESET;
			outer_reg = OUTER_CFG_W'(1);
			inner_reg = INNER_CFG_W'(1);
			row_at = 0;
			col_at = 0;
			due_cells.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_cells.size() == 0) begin
					$error("unexpected result beat: conc_out %0h, count_out %0h, last_cell %0b",
						conc_out, count_out, last_cell);
					failures++;
				end else begin
					want = due_cells.pop_front();
					if (conc_out !== want.conc) begin
						$error("conc_out mismatch: expected %0h, actual %0h", want.conc, conc_out);
						failures++;
					end
					if (count_out !== want.count) begin
						$error("count_out mismatch: expected %0h, actual %0h",
							want.count, count_out);
						failures++;
					end
					if (last_cell !== want.last) begin
						$error("last_cell mismatch: expected %0b, actual %0b",
							want.last, last_cell);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FOURIER: fo_reg = cfg_data[FO_W-1:0];
					CFG_SCALE:   scale_reg = cfg_data[SCALE_W-1:0];
					CFG_OUTER: begin
						outer_reg = cfg_data[OUTER_CFG_W-1:0];
						row_at = 0;
						col_at = 0;
					end
					CFG_INNER: begin
						inner_reg = cfg_data[INNER_CFG_W-1:0];
						row_at = 0;
						col_at = 0;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall) absorb_cell(conc_in);
		end
		pending = due_cells.size();
	end

endmodule

// ===== sim/diffusion_stencil_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffusion_stencil_step_test: stimulus and verdict for the stencil step
// Runs a short directed set of grids covering value extremes and register
// corner cases, then random grids of mostly small size under three patterns
// of sender and receiver idling. The checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module diffusion_stencil_step_test;
	import dsst_pkg::*;

	localparam int SETTLE_CYCLES  = 30;
	localparam int STALL_LIMIT    = 2000;
	localparam int PHASE_CELLS    = 72;
	localparam int GRID_INNER_MAX = 32;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = CFG_FOURIER;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CONC_W-1:0]     conc_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CONC_W-1:0]     conc_out;
	logic [COUNT_W-1:0]    count_out;
	logic                  last_cell;
	int                    pending;
	int                    failures;

	int                    send_idle = 0;
	int                    recv_idle = 0;
	int                    cells_sent = 0;
	int                    quiet_cycles = 0;
	int unsigned           grid_n = 1;
	int unsigned           grid_m = 1;
	logic                  grid_broken = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	diffusion_stencil_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.conc_in   (conc_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.conc_out  (conc_out),
		.count_out (count_out),
		.last_cell (last_cell)
	);

	diffusion_stencil_step_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.conc_in   (conc_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.conc_out  (conc_out),
		.count_out (count_out),
		.last_cell (last_cell),
		.pending   (pending),
		.failures  (failures)
	);

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// Watchdog: ends the run when no channel has moved a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("FAIL diffusion_stencil_step");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one cell, with random idle cycles in front of it.
	task automatic send_cell(input logic [CONC_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		conc_in <= value;
		do @(posedge clk); while (in_stall);
		cells_sent++;
	endtask

	// Stops sending and waits until the block has drained and gone quiet.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the channel drops valid again before the task returns.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CONC_W-1:0] pick_conc();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16) return '1;
		if (r < 40) return CONC_W'($urandom_range(0, 65535));
		return CONC_W'($urandom());
	endfunction

	// One random grid: new registers now and then, sometimes cut short so
	// that the next grid restarts through a size write.
	task automatic run_random_grid();
		int unsigned pick;
		int unsigned rows;
		int unsigned cols;
		int unsigned cells;
		int unsigned outer_raw;
		int unsigned inner_raw;
		int unsigned fo_val;
		logic [SCALE_W-1:0] scale_val;
		logic resize;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			rows = 1;
			cols = $urandom_range(1, 12);
		end else if (pick < 20) begin
			rows = $urandom_range(2, 10);
			cols = 1;
		end else if (pick < 25) begin
			rows = 2;
			cols = $urandom_range(20, GRID_INNER_MAX);
		end else begin
			rows = $urandom_range(2, 5);
			cols = $urandom_range(2, 8);
		end
		outer_raw = (rows == 1 && $urandom_range(0, 1) == 1) ? 0 : rows;
		inner_raw = cols;
		if (cols == 1 && $urandom_range(0, 1) == 1) inner_raw = 0;
		if (cols == GRID_INNER_MAX && $urandom_range(0, 1) == 1)
			inner_raw = $urandom_range(GRID_INNER_MAX + 1, 2 ** INNER_CFG_W - 1);

		pick = $urandom_range(0, 99);
		if (pick < 10) fo_val = 0;
		else if (pick < 20) fo_val = FO_MAX;
		else if (pick < 30) fo_val = $urandom_range(FO_MAX + 1, 2 ** FO_W - 1);
		else fo_val = $urandom_range(0, FO_MAX);

		pick = $urandom_range(0, 99);
		if (pick < 25) scale_val = $urandom();
		else if (pick < 45) scale_val = SCALE_RESET;
		else scale_val = $urandom_range(0, 1 << 20);

		resize = grid_broken || ($urandom_range(0, 99) < 70);
		if (resize) begin
			grid_n = rows;
			grid_m = cols;
		end

		// Back-to-back grids keep the old settings and follow the wrap.
		if (resize || $urandom_range(0, 1) == 1) begin
			settle_block();
			write_reg(CFG_FOURIER, fo_val);
			write_reg(CFG_SCALE, scale_val);
			if (resize) begin
				write_reg(CFG_OUTER, outer_raw);
				write_reg(CFG_INNER, inner_raw);
			end
		end

		cells = grid_n * grid_m;
		grid_broken = 1'b0;
		if (cells > 2 && $urandom_range(0, 9) == 0) begin
			cells = $urandom_range(1, cells - 1);
			grid_broken = 1'b1;
		end
		repeat (cells) send_cell(pick_conc());
	endtask

	initial begin
		int phase_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one-cell grid, passed through; unit scale saturates.
		send_cell(32'h0000_0000);
		send_cell(32'hFFFF_FFFF);
		settle_block();

		// Fourier beyond 0.25, full scale, zero rows, too many columns.
		write_reg(CFG_SCALE, 32'hFFFF_FFFF);
		write_reg(CFG_FOURIER, 32'h0000_7FFF);
		write_reg(CFG_OUTER, 32'd0);
		write_reg(CFG_INNER, 32'd63);
		send_cell(32'h0000_0001);
		send_cell(32'h8000_0000);
		settle_block();

		// Too many rows with a single column.
		write_reg(CFG_OUTER, 32'd2047);
		write_reg(CFG_INNER, 32'd1);
		send_cell(32'h1234_5678);
		settle_block();

		// Smallest real grid with extreme values.
		write_reg(CFG_OUTER, 32'd2);
		write_reg(CFG_INNER, 32'd2);
		send_cell(32'hFFFF_FFFF);
		send_cell(32'h0000_0000);
		send_cell(32'h0000_0000);
		send_cell(32'hFFFF_FFFF);
		settle_block();

		// 3x3 grid: the first row returns nothing; Fourier and scale change
		// between the first row and the rest.
		write_reg(CFG_FOURIER, FO_MAX);
		write_reg(CFG_SCALE, 32'd0);
		write_reg(CFG_OUTER, 32'd3);
		write_reg(CFG_INNER, 32'd3);
		send_cell(32'hFFFF_FFFF);
		send_cell(32'h0000_0000);
		send_cell(32'hFFFF_FFFF);
		settle_block();
		write_reg(CFG_FOURIER, 32'd4321);
		write_reg(CFG_SCALE, SCALE_RESET);
		repeat (6) send_cell(pick_conc());

		// Wrap into a new grid, then restart it with a size write.
		send_cell(pick_conc());
		send_cell(pick_conc());
		settle_block();
		write_reg(CFG_OUTER, 32'd2);
		write_reg(CFG_INNER, 32'd2);
		repeat (4) send_cell(pick_conc());
		grid_n = 2;
		grid_m = 2;

		// Random grids under three idling patterns.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 22 : (phase == 1) ? 83 : 0;
			recv_idle = (phase == 0) ? 83 : (phase == 1) ? 22 : 0;
			phase_start = cells_sent;
			while (cells_sent - phase_start < PHASE_CELLS) run_random_grid();
		end

		settle_block();
		if (failures == 0) begin
			$display("PASS diffusion_stencil_step");
		end else begin
			$display("FAIL diffusion_stencil_step");
		end
		$finish;
	end

endmodule
